// ----- hw/rtl/sorted_value_list_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Sorted value list assertion macros
// Concurrent assertion helpers clocked by i_clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_VALUE_LIST_UNIT_DEFINES_SVH
`define SORTED_VALUE_LIST_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define SVLU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
`define SVLU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SVLU_ASSERT(label, prop, msg)
`define SVLU_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ----- hw/rtl/svlu_pkg.sv -----
// ----------------------------------------------------------------------------
// Sorted value list package
// Sizes, codes and the control word shared by the list cells.
// ----------------------------------------------------------------------------
`default_nettype none
package svlu_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int FILL_W   = 5;

    typedef logic signed [31:0] t_word;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_DUMP   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2,
        OP_ROTATE = 2'd3
    } t_cell_op;

    typedef struct packed {
        t_cell_op          op;
        t_word             value;
        logic [CNT_W-1:0]  count;
    } t_cell_ctl;

endpackage
`default_nettype wire

// ----- hw/rtl/svlu_ifs.sv -----
// ----------------------------------------------------------------------------
// Sorted value list channels
// Valid/ready channels for request words and response words.
// ----------------------------------------------------------------------------
`default_nettype none
interface svlu_in_if;
    logic                 valid;
    logic                 ready;
    logic [1:0]           command;
    logic signed [31:0]   value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

interface svlu_out_if;
    logic                 valid;
    logic                 ready;
    logic [1:0]           status;
    logic signed [31:0]   entry_value;
    logic [4:0]           fill_count;
    logic                 last;

    modport source (output valid, output status, output entry_value,
                    output fill_count, output last, input ready);
    modport sink   (input valid, input status, input entry_value,
                    input fill_count, input last, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/svlu_cell.sv -----
// ----------------------------------------------------------------------------
// Sorted value list cell
// Holds one entry and moves it to or from its neighbors on insert, delete
// and rotate.
// ----------------------------------------------------------------------------
`default_nettype none
module svlu_cell (
    input  logic                      i_clk,
    input  svlu_pkg::t_cell_ctl       i_ctl,
    input  logic [svlu_pkg::CNT_W-1:0] i_index,
    input  svlu_pkg::t_word           i_prev_val,
    input  svlu_pkg::t_word           i_next_val,
    input  svlu_pkg::t_word           i_head_val,
    input  logic                      i_prev_lt,
    input  logic                      i_prev_hit,
    output svlu_pkg::t_word           o_val,
    output logic                      o_lt,
    output logic                      o_hit
);
    import svlu_pkg::*;

    t_word r_val;
    t_word n_val;
    logic  w_valid;

    assign w_valid = (i_index < i_ctl.count);
    assign o_lt    = w_valid && (r_val < i_ctl.value);
    assign o_hit   = i_prev_hit || (w_valid && (r_val == i_ctl.value));
    assign o_val   = r_val;

    always_comb begin
        n_val = r_val;
        unique case (i_ctl.op)
            OP_HOLD: n_val = r_val;
            OP_INSERT: begin
                if (o_lt) begin
                    n_val = r_val;
                end else if (i_prev_lt) begin
                    n_val = i_ctl.value;
                end else begin
                    n_val = i_prev_val;
                end
            end
            OP_DELETE: n_val = o_hit ? i_next_val : r_val;
            OP_ROTATE: begin
                if (!w_valid) begin
                    n_val = r_val;
                end else if (i_index == i_ctl.count - 1'b1) begin
                    n_val = i_head_val;
                end else begin
                    n_val = i_next_val;
                end
            end
            default: n_val = r_val;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule
`default_nettype wire

// ----- hw/rtl/sorted_value_list_unit.sv -----
// ----------------------------------------------------------------------------
// Sorted value list unit
// Ascending table of signed words built from a row of cells.
// ----------------------------------------------------------------------------
// Channel  Direction  Fields
// i_req    in         command, value
// o_rsp    out        status, entry_value, fill_count, last
//
// Insert, delete and clear each give one response word.
// A dump gives one response word per entry, rotating the row to bring each
// entry to the head; the request port stays closed meanwhile.
// A response word that waits untaken closes the request port until it is taken.
// Reset clears the fill count; entry contents are not reset.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sorted_value_list_unit_defines.svh"
module sorted_value_list_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    svlu_in_if.sink     i_req,
    svlu_out_if.source  o_rsp
);
    import svlu_pkg::*;

    typedef enum logic {S_IDLE, S_DUMP} t_state;

    localparam logic [CNT_W-1:0] CAP = CNT_W'(CAPACITY);

    t_state             r_state;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_dcnt;
    logic               r_ovld;
    t_status            r_ostatus;
    t_word              r_oval;
    logic [FILL_W-1:0]  r_ofill;
    logic               r_olast;

    logic       w_accept;
    logic       w_out_free;
    logic       w_found;
    logic       w_dump_last;
    logic       w_insert_go;
    logic       w_load;
    t_cmd       w_cmd;
    t_cell_ctl  w_ctl;

    t_word w_val  [CAPACITY];
    t_word w_prev [CAPACITY];
    t_word w_next [CAPACITY];
    logic  w_lt   [CAPACITY];
    logic  w_hit  [CAPACITY];
    logic  w_plt  [CAPACITY];
    logic  w_phit [CAPACITY];

    assign w_out_free  = !r_ovld || o_rsp.ready;
    assign i_req.ready = (r_state == S_IDLE) && w_out_free;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_cmd       = t_cmd'(i_req.command);
    assign w_found     = w_hit[CAPACITY-1];
    assign w_dump_last = (r_dcnt == r_count - 1'b1);
    assign w_insert_go = w_accept && (w_cmd == CMD_INSERT) && (r_count < CAP);
    assign w_load      = (w_accept && ((w_cmd != CMD_DUMP) || (r_count == '0)))
                       || ((r_state == S_DUMP) && w_out_free);

    always_comb begin
        w_ctl.value = i_req.value;
        w_ctl.count = r_count;
        w_ctl.op    = OP_HOLD;
        if (w_insert_go) begin
            w_ctl.op = OP_INSERT;
        end else if (w_accept && (w_cmd == CMD_DELETE)) begin
            w_ctl.op = OP_DELETE;
        end else if ((r_state == S_DUMP) && w_out_free) begin
            w_ctl.op = OP_ROTATE;
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign w_prev[g] = i_req.value;
            assign w_plt[g]  = 1'b1;
            assign w_phit[g] = 1'b0;
        end else begin : g_mid
            assign w_prev[g] = w_val[g-1];
            assign w_plt[g]  = w_lt[g-1];
            assign w_phit[g] = w_hit[g-1];
        end
        if (g == CAPACITY - 1) begin : g_end
            assign w_next[g] = w_val[g];
        end else begin : g_inner
            assign w_next[g] = w_val[g+1];
        end

        svlu_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_index    (CNT_W'(g)),
            .i_prev_val (w_prev[g]),
            .i_next_val (w_next[g]),
            .i_head_val (w_val[0]),
            .i_prev_lt  (w_plt[g]),
            .i_prev_hit (w_phit[g]),
            .o_val      (w_val[g]),
            .o_lt       (w_lt[g]),
            .o_hit      (w_hit[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_dcnt  <= '0;
            r_ovld  <= 1'b0;
        end else begin
            if (o_rsp.ready && !w_load) begin
                r_ovld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_oval  <= i_req.value;
                        r_olast <= 1'b1;
                        unique case (w_cmd)
                            CMD_INSERT: begin
                                r_ovld <= 1'b1;
                                if (r_count >= CAP) begin
                                    r_ostatus <= ST_FULL;
                                    r_ofill   <= FILL_W'(r_count);
                                end else begin
                                    r_ostatus <= ST_OK;
                                    r_ofill   <= FILL_W'(r_count + 1'b1);
                                    r_count   <= r_count + 1'b1;
                                end
                            end
                            CMD_DELETE: begin
                                r_ovld <= 1'b1;
                                if (r_count == '0) begin
                                    r_ostatus <= ST_EMPTY;
                                    r_ofill   <= '0;
                                end else if (!w_found) begin
                                    r_ostatus <= ST_NOTFOUND;
                                    r_ofill   <= FILL_W'(r_count);
                                end else begin
                                    r_ostatus <= ST_OK;
                                    r_ofill   <= FILL_W'(r_count - 1'b1);
                                    r_count   <= r_count - 1'b1;
                                end
                            end
                            CMD_CLEAR: begin
                                r_ovld    <= 1'b1;
                                r_ostatus <= ST_OK;
                                r_ofill   <= '0;
                                r_count   <= '0;
                            end
                            CMD_DUMP: begin
                                if (r_count == '0) begin
                                    r_ovld    <= 1'b1;
                                    r_ostatus <= ST_EMPTY;
                                    r_ofill   <= '0;
                                end else begin
                                    r_dcnt  <= '0;
                                    r_state <= S_DUMP;
                                end
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_DUMP: begin
                    if (w_out_free) begin
                        r_ovld    <= 1'b1;
                        r_ostatus <= ST_OK;
                        r_oval    <= w_val[0];
                        r_ofill   <= FILL_W'(r_count);
                        r_olast   <= w_dump_last;
                        r_dcnt    <= r_dcnt + 1'b1;
                        if (w_dump_last) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.valid       = r_ovld;
    assign o_rsp.status      = r_ostatus;
    assign o_rsp.entry_value = r_oval;
    assign o_rsp.fill_count  = r_ofill;
    assign o_rsp.last        = r_olast;

    `SVLU_ASSERT(a_count_bound, r_count <= CAP, "fill count above capacity")
    `SVLU_ASSERT(a_dump_index, (r_state != S_DUMP) || (r_dcnt < r_count), "dump index overrun")
    `SVLU_ASSERT_NEXT(a_insert_grows, w_insert_go, r_count == $past(r_count) + 1'b1, "count stuck")

endmodule
`default_nettype wire

// ----- tb/sorted_value_list_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted value list unit testbench
// Drives insert, delete, clear and dump requests with random bursts and gaps.
// A software copy of the sorted table predicts every response word, and each
// word taken from the unit is compared field by field against it.
// ----------------------------------------------------------------------------
module sorted_value_list_unit_test;
    import svlu_pkg::*;

    localparam int IDLE_LIMIT    = 2000;
    localparam int HOLD_CYCLES   = 200;
    localparam int TAIL_CYCLES   = 24;
    localparam int RANDOM_ITEMS  = 420;
    localparam int REPORT_LIMIT  = 100;

    typedef struct {
        t_status     status;
        t_word       entry_value;
        logic [4:0]  fill_count;
        logic        last;
    } t_rsp_word;

    logic i_clk = 1'b0;
    logic i_rst_n;

    svlu_in_if  req_ch ();
    svlu_out_if rsp_ch ();

    sorted_value_list_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    t_word      held [CAPACITY];
    int         held_count;
    t_rsp_word  awaited_words [$];

    int failures;
    int requests_sent;
    int words_checked;
    int dumps_sent;
    int full_drops;
    int delete_misses;
    int empty_hits;
    int burst_left;
    int hold_request;
    int hold_left;
    int stall_mode;
    int mode_left;
    int stall_phase;
    int idle_cycles;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void predict_list_op(t_cmd cmd, t_word val);
        t_rsp_word w;
        int        pos;
        int        j;
        w.status      = ST_OK;
        w.entry_value = val;
        w.last        = 1'b1;
        case (cmd)
            CMD_INSERT: begin
                if (held_count >= CAPACITY) begin
                    w.status = ST_FULL;
                    full_drops++;
                end else begin
                    pos = 0;
                    while (pos < held_count && held[pos] < val) pos++;
                    for (j = held_count; j > pos; j--) held[j] = held[j - 1];
                    held[pos] = val;
                    held_count++;
                end
                w.fill_count = 5'(held_count);
            end
            CMD_DELETE: begin
                if (held_count == 0) begin
                    w.status = ST_EMPTY;
                    empty_hits++;
                end else begin
                    pos = 0;
                    while (pos < held_count && held[pos] != val) pos++;
                    if (pos == held_count) begin
                        w.status = ST_NOTFOUND;
                        delete_misses++;
                    end else begin
                        for (j = pos; j + 1 < held_count; j++) held[j] = held[j + 1];
                        held_count--;
                    end
                end
                w.fill_count = 5'(held_count);
            end
            CMD_CLEAR: begin
                held_count   = 0;
                w.fill_count = 5'd0;
            end
            default: begin
                dumps_sent++;
                if (held_count == 0) begin
                    w.status     = ST_EMPTY;
                    w.fill_count = 5'd0;
                    empty_hits++;
                end else begin
                    for (j = 0; j < held_count; j++) begin
                        w.entry_value = held[j];
                        w.fill_count  = 5'(held_count);
                        w.last        = (j + 1 == held_count);
                        awaited_words.push_back(w);
                    end
                    return;
                end
            end
        endcase
        awaited_words.push_back(w);
    endfunction

    function automatic t_word pick_value();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 4) begin
            return t_word'(int'($urandom_range(0, 15)) - 8);
        end else if (sel == 4) begin
            case ($urandom_range(0, 3))
                0: return 32'sh7FFF_FFFF;
                1: return 32'sh8000_0000;
                2: return 32'sh0000_0000;
                default: return -32'sd1;
            endcase
        end
        return t_word'($urandom);
    endfunction

    task automatic send_request(t_cmd cmd, t_word val);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        req_ch.valid   <= 1'b1;
        req_ch.command <= cmd;
        req_ch.value   <= val;
        do @(posedge i_clk); while (!req_ch.ready);
        predict_list_op(cmd, val);
        requests_sent++;
        burst_left--;
    endtask

    task automatic send_random_request(int insert_weight);
        int unsigned roll;
        t_word       val;
        roll = $urandom_range(0, 99);
        if (roll < 2) begin
            send_request(CMD_CLEAR, t_word'($urandom));
        end else if (roll < 12) begin
            send_request(CMD_DUMP, t_word'($urandom));
        end else if (roll < 12 + (88 * insert_weight) / 100) begin
            send_request(CMD_INSERT, pick_value());
        end else begin
            if (held_count > 0 && $urandom_range(0, 1) == 1) begin
                val = held[$urandom_range(0, held_count - 1)];
            end else begin
                val = pick_value();
            end
            send_request(CMD_DELETE, val);
        end
    endtask

    task automatic report_mismatch(string field, longint expected_val, longint actual_val);
        failures++;
        if (failures <= REPORT_LIMIT) begin
            $error("%s: expected %0d, got %0d", field, expected_val, actual_val);
        end
    endtask

    task automatic test_empty_table();
        send_request(CMD_DUMP, 32'sh5A5A_A5A5);
        send_request(CMD_DELETE, 32'sd7);
    endtask

    task automatic test_extremes_and_duplicates();
        send_request(CMD_INSERT, 32'sh7FFF_FFFF);
        send_request(CMD_INSERT, 32'sh8000_0000);
        send_request(CMD_INSERT, 32'sd0);
        send_request(CMD_INSERT, -32'sd1);
        send_request(CMD_INSERT, 32'sd0);
        send_request(CMD_DUMP, 32'sd0);
        send_request(CMD_DELETE, 32'sd12345);
        send_request(CMD_DELETE, 32'sd0);
    endtask

    task automatic test_fill_to_capacity();
        while (held_count < CAPACITY) send_request(CMD_INSERT, pick_value());
        send_request(CMD_INSERT, 32'sd99);
        send_request(CMD_DUMP, 32'sd0);
    endtask

    task automatic test_clear();
        send_request(CMD_CLEAR, 32'sh1234_5678);
        send_request(CMD_DUMP, -32'sd42);
    endtask

    task automatic test_backpressure();
        hold_request = 1;
        repeat (24) send_random_request(70);
    endtask

    task automatic test_random_mix();
        int phase_len;
        int weight;
        int sent;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            phase_len = $urandom_range(20, 60);
            case ($urandom_range(0, 2))
                0: weight = 85;
                1: weight = 55;
                default: weight = 25;
            endcase
            repeat (phase_len) begin
                if (sent < RANDOM_ITEMS) begin
                    send_random_request(weight);
                    sent++;
                end
            end
        end
    endtask

    initial begin
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
                words_checked++;
                if (awaited_words.size() == 0) begin
                    failures++;
                    $error("response word arrived with nothing pending");
                end else begin
                    if (rsp_ch.status !== awaited_words[0].status)
                        report_mismatch("status", awaited_words[0].status, rsp_ch.status);
                    if (rsp_ch.entry_value !== awaited_words[0].entry_value)
                        report_mismatch("entry_value", awaited_words[0].entry_value,
                                        rsp_ch.entry_value);
                    if (rsp_ch.fill_count !== awaited_words[0].fill_count)
                        report_mismatch("fill_count", awaited_words[0].fill_count,
                                        rsp_ch.fill_count);
                    if (rsp_ch.last !== awaited_words[0].last)
                        report_mismatch("last", awaited_words[0].last, rsp_ch.last);
                    void'(awaited_words.pop_front());
                end
            end
            if (hold_request != 0) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 0;
            end
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(30, 150);
            end
            mode_left--;
            stall_phase = !stall_phase;
            if (hold_left > 0) begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end else begin
                case (stall_mode)
                    0: rsp_ch.ready <= 1'b1;
                    1: rsp_ch.ready <= ($urandom_range(0, 9) < 7);
                    2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: rsp_ch.ready <= stall_phase[0];
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("No word moved for %0d cycles; %0d responses still pending.",
                         IDLE_LIMIT, awaited_words.size());
                $display("sorted_value_list_unit: mismatch");
                $finish;
            end
        end
    end

    initial begin
        failures       = 0;
        requests_sent  = 0;
        words_checked  = 0;
        dumps_sent     = 0;
        full_drops     = 0;
        delete_misses  = 0;
        empty_hits     = 0;
        burst_left     = 0;
        hold_request   = 0;
        hold_left      = 0;
        stall_mode     = 0;
        mode_left      = 0;
        stall_phase    = 0;
        idle_cycles    = 0;
        held_count     = 0;
        i_rst_n        <= 1'b0;
        req_ch.valid   <= 1'b0;
        req_ch.command <= CMD_INSERT;
        req_ch.value   <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_table();
        test_extremes_and_duplicates();
        test_fill_to_capacity();
        test_clear();
        test_backpressure();
        test_random_mix();

        req_ch.valid <= 1'b0;
        while (awaited_words.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d requests (%0d dumps) and checked %0d response words.",
                 requests_sent, dumps_sent, words_checked);
        $display("Saw %0d inserts dropped when full, %0d delete misses, %0d empty-table hits.",
                 full_drops, delete_misses, empty_hits);
        if (failures == 0) begin
            $display("sorted_value_list_unit: match");
        end else begin
            $display("sorted_value_list_unit: mismatch");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/svlu_pkg.sv
hw/rtl/svlu_ifs.sv
hw/rtl/svlu_cell.sv
hw/rtl/sorted_value_list_unit.sv
tb/sorted_value_list_unit_test.sv
